>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FFPA_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define FFPA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ffpa_pkg.sv
// ---------------------------------------------------------------------------
// ffpa_pkg
// Types and constants shared by the pool allocator cells and top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int ADDR_W     = 7;
    localparam int SIZE_W     = 8;
    localparam int ADDR_REACH = 128;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_MARK,
        OP_FREE
    } op_t;

    // token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic              done;
        logic              found;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] run;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] rem;
    } tok_t;

endpackage

>>> rtl/ffpa_cell.sv
// ---------------------------------------------------------------------------
// ffpa_cell
// One pool unit: busy flag, block head flag and block length. Updates the
// passing token and hands it to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_cell
    import ffpa_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok_in,
    output tok_t tok_out
);

    localparam bit              IN_REACH = (IDX < ADDR_REACH);
    localparam logic [ADDR_W-1:0] IDX_A  = ADDR_W'(IDX % ADDR_REACH);

    logic              busy_reg, busy_next;
    logic              head_reg, head_next;
    logic [SIZE_W-1:0] len_reg,  len_next;
    tok_t              tok_reg,  tok_next;

    logic              is_me;
    logic [SIZE_W-1:0] run_inc;

    assign is_me   = IN_REACH && (tok_in.start == IDX_A);
    assign run_inc = tok_in.run + SIZE_W'(1);

    always_comb
    begin
        busy_next = busy_reg;
        head_next = head_reg;
        len_next  = len_reg;
        tok_next  = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.op)
                OP_SCAN:
                begin
                    if (!tok_in.done)
                    begin
                        if (busy_reg)
                        begin
                            tok_next.run = '0;
                        end
                        else if ((tok_in.run == '0) && !IN_REACH)
                        begin
                            tok_next.done = 1'b1;
                        end
                        else
                        begin
                            if (tok_in.run == '0)
                            begin
                                tok_next.start = IDX_A;
                            end
                            tok_next.run = run_inc;
                            if (run_inc == tok_in.size)
                            begin
                                tok_next.found = 1'b1;
                                tok_next.done  = 1'b1;
                            end
                        end
                    end
                end
                OP_MARK:
                begin
                    if (is_me)
                    begin
                        busy_next    = 1'b1;
                        head_next    = 1'b1;
                        len_next     = tok_in.size;
                        tok_next.rem = tok_in.size - SIZE_W'(1);
                    end
                    else if (tok_in.rem != '0)
                    begin
                        busy_next    = 1'b1;
                        tok_next.rem = tok_in.rem - SIZE_W'(1);
                    end
                end
                OP_FREE:
                begin
                    if (is_me && head_reg)
                    begin
                        busy_next      = 1'b0;
                        head_next      = 1'b0;
                        tok_next.found = 1'b1;
                        tok_next.rem   = len_reg - SIZE_W'(1);
                    end
                    else if (tok_in.rem != '0)
                    begin
                        busy_next    = 1'b0;
                        tok_next.rem = tok_in.rem - SIZE_W'(1);
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            head_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            head_reg <= head_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/first_fit_pool_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit allocator over a pool of equal units, with merged free runs.
// ---------------------------------------------------------------------------
// Request channel (req_valid / req_stall): command 0 allocates request_size
// units, command 1 releases the block starting at release_address. One
// request is taken at a time; req_stall is high until its work is done.
// Response channel (rsp_valid / rsp_stall): one transfer per request with
// granted_address and success, held in an output register.
// The pool is a chain of POOL_UNITS cells; a token steps one cell per cycle.
// Allocate: a scan pass finds the first fitting run, then a mark pass sets
// the units busy. A failed allocate and any release take one pass.
// A stalled response is held; a finished request waits in a holding slot
// and the next request is taken once the output register is free again.
// Reset leaves the whole pool free with no live allocations.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module first_fit_pool_allocator
    import ffpa_pkg::*;
#(
    parameter int POOL_UNITS = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              command,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [ADDR_W-1:0] release_address,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [ADDR_W-1:0] granted_address,
    output logic              success
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t            state_reg, state_next;
    tok_t              inj_reg, inj_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_succ_reg, out_succ_next;
    logic [ADDR_W-1:0] hold_addr_reg, hold_addr_next;
    logic              hold_succ_reg, hold_succ_next;

    tok_t              chain [POOL_UNITS+1];
    tok_t              tail;
    logic              res_succ;
    logic [ADDR_W-1:0] res_addr;
    logic              out_free;

    assign chain[0] = inj_reg;
    assign tail     = chain[POOL_UNITS];

    genvar gi;
    generate
        for (gi = 0; gi < POOL_UNITS; gi++)
        begin : g_cell
            ffpa_cell #(.IDX(gi)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign out_free = !out_valid_reg || !rsp_stall;
    assign res_succ = (tail.op == OP_MARK) || ((tail.op == OP_FREE) && tail.found);
    assign res_addr = (tail.op == OP_MARK) ? tail.start : '0;

    always_comb
    begin
        state_next     = state_reg;
        inj_next       = '0;
        out_valid_next = out_valid_reg && rsp_stall;
        out_addr_next  = out_addr_reg;
        out_succ_next  = out_succ_reg;
        hold_addr_next = hold_addr_reg;
        hold_succ_next = hold_succ_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    inj_next.valid = 1'b1;
                    inj_next.op    = command ? OP_FREE : OP_SCAN;
                    inj_next.size  = request_size;
                    inj_next.start = command ? release_address : '0;
                    inj_next.done  = !command && (request_size == '0);
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tail.valid)
                begin
                    if ((tail.op == OP_SCAN) && tail.found)
                    begin
                        inj_next.valid = 1'b1;
                        inj_next.op    = OP_MARK;
                        inj_next.size  = tail.size;
                        inj_next.start = tail.start;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_addr_next  = res_addr;
                        out_succ_next  = res_succ;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        hold_addr_next = res_addr;
                        hold_succ_next = res_succ;
                        state_next     = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = hold_addr_reg;
                    out_succ_next  = hold_succ_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inj_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_addr_reg  <= '0;
            out_succ_reg  <= 1'b0;
            hold_addr_reg <= '0;
            hold_succ_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
            out_addr_reg  <= out_addr_next;
            out_succ_reg  <= out_succ_next;
            hold_addr_reg <= hold_addr_next;
            hold_succ_reg <= hold_succ_next;
        end
    end

    assign req_stall       = (state_reg != ST_IDLE);
    assign rsp_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign success         = out_succ_reg;

    `FFPA_ASSERT_SAME(a_tail_in_run, clk, rst_n, tail.valid, state_reg == ST_RUN)
    `FFPA_ASSERT_NEXT(a_accept_injects, clk, rst_n, req_valid && !req_stall, inj_reg.valid)
    `FFPA_ASSERT_SAME(a_rsp_from_busy, clk, rst_n, $rose(out_valid_reg), $past(state_reg) != ST_IDLE)
    `FFPA_ASSERT_SAME(a_addr_on_grant, clk, rst_n, rsp_valid && (granted_address != '0), success)

endmodule
